// ----- sv/seqrx_pkg.sv -----
`default_nettype none

package seqrx_pkg;

	localparam int unsigned PROGRESS_EVERY_DEF = 5;
	localparam int unsigned MAX_PACKET_BYTES   = 4096;
	localparam logic [3:0]  FAIL_LIMIT_RESET   = 4'd5;
	localparam logic [15:0] GIVE_UP_ACK        = 16'hFFFF;
	localparam logic [31:0] CRC_POLY           = 32'hEDB88320;

	typedef enum logic [1:0] {
		FUNC_HEADER = 2'd0,
		FUNC_DATA   = 2'd1,
		FUNC_POLL   = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_END    = 2'd2,
		KIND_POLL   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_SHORT     = 4'd1,
		ST_BUSY_ACK  = 4'd2,
		ST_UNEXPECT  = 4'd3,
		ST_TOPIC     = 4'd4,
		ST_BOUNDS    = 4'd5,
		ST_SKIP      = 4'd6,
		ST_DUPLICATE = 4'd7,
		ST_CRC_MISS  = 4'd8,
		ST_CRC_BAD   = 4'd9,
		ST_COMPLETE  = 4'd10
	} status_t;

	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_ACK      = 2'd1,
		EV_PROGRESS = 2'd2
	} event_t;

	// reflected CRC-32, one byte, complemented in and out
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = ~crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return ~c;
	endfunction

endpackage

`default_nettype wire

// ----- sv/sequenced_transfer_receiver_unit.sv -----
// Flow: a word accepted on s_axis is captured in the input register, decoded from there, and its
//   result word is registered in the result register and offered on m_axis.
// Throughput: one word per cycle unless s_axis stalls; the per-byte CRC-32 update is one
//   8-step combinational fold. A result word held back by m_axis_tready stalls s_axis only
//   once the input register is full. Words with selector 3 produce no result word.
// Reset: arst_n clears all transfer state, both pipeline valids and sets fail_limit to 5.
`default_nettype none

module sequenced_transfer_receiver_unit #(
	parameter int unsigned PROGRESS_EVERY = seqrx_pkg::PROGRESS_EVERY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: fail_limit
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_wdata,
	// input stream
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	// tdata, low bit up: topic_id[7:0], pkt_no[15:0], pkt_total[15:0],
	//   data_length[12:0], short_header, data_byte[7:0], link_ready, one zero pad bit
	input  wire logic [63:0] s_axis_tdata,
	// tuser: func[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	// result stream
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// tdata, low bit up: status[3:0], data_out[7:0], packet_offset[15:0], last_pkt,
	//   event_kind[1:0], event_value[15:0], one zero pad bit
	output      logic [47:0] m_axis_tdata,
	// tuser, low bit up: result_kind[1:0], deliver
	output      logic [2:0]  m_axis_tuser
);

	import seqrx_pkg::*;

	// expected_packet modulo PROGRESS_EVERY is tracked alongside it, so the progress
	// trigger needs no divider
	localparam int unsigned MW         = $clog2(PROGRESS_EVERY + 1);
	localparam int unsigned FFFF_MOD_I = 65535 % PROGRESS_EVERY;
	localparam logic [MW-1:0] FFFF_MOD = MW'(FFFF_MOD_I);
	localparam logic [MW-1:0] MOD_TOP  = MW'(PROGRESS_EVERY - 1);

	typedef struct packed {
		logic          tv;     // transfer valid
		logic [7:0]    topic;
		logic [15:0]   exp;    // expected packet
		logic [MW-1:0] emod;   // exp modulo PROGRESS_EVERY
		logic [15:0]   total;
		logic [31:0]   crc;    // running CRC
		logic [3:0]    fc;     // failure count
		logic          ap;     // ack pending
		logic          pp;     // progress pending
		logic [15:0]   ackv;
		logic          pa;     // packet accepted
		logic          fp;     // final packet
		logic [12:0]   bi;     // byte index
		logic [12:0]   pl;     // packet length
		logic [31:0]   rc;     // received CRC
	} st_t;

	function automatic st_t f_send_ack(st_t s, logic [15:0] v, logic [MW-1:0] vm);
		s.ackv = v;
		s.exp  = v;
		s.emod = vm;
		s.ap   = 1'b1;
		s.pp   = 1'b0;
		return s;
	endfunction

	function automatic st_t f_drop(st_t s, logic [15:0] to, logic [MW-1:0] tm);
		s.tv   = 1'b0;
		s.exp  = to;
		s.emod = tm;
		if (to == 16'd0) begin
			s.total = 16'd0;
			s.crc   = 32'd0;
		end
		return s;
	endfunction

	// count a failure; reaching the limit gives up with an all-ones ack
	function automatic st_t f_fail(st_t s, logic [3:0] lim);
		if (s.fc != 4'hF) begin
			s.fc = s.fc + 4'd1;
		end
		if (s.fc >= lim) begin
			s = f_drop(s, 16'd0, '0);
			s = f_send_ack(s, GIVE_UP_ACK, FFFF_MOD);
		end
		return s;
	endfunction

	// registers
	logic [3:0]  fail_limit_q;
	st_t         st_q;
	logic        valid_s1;
	func_t       func_s1;
	logic [7:0]  topic_s1;
	logic [15:0] pnum_s1;
	logic [15:0] ptot_s1;
	logic [12:0] dlen_s1;
	logic        short_s1;
	logic [7:0]  byte_s1;
	logic        ready_s1;
	logic        valid_s2;
	kind_t       kind_s2;
	status_t     status_s2;
	logic        deliver_s2;
	logic [7:0]  dout_s2;
	logic [15:0] offset_s2;
	logic        lastp_s2;
	event_t      ek_s2;
	logic [15:0] ev_s2;

	// decode results
	st_t         st_n;
	logic        has_result;
	kind_t       r_kind;
	status_t     r_status;
	logic        r_deliver;
	logic [7:0]  r_dout;
	logic [15:0] r_offset;
	logic        r_lastp;
	event_t      r_ek;
	logic [15:0] r_ev;
	logic        hdr_ok;
	logic        crc_miss;
	logic        end_r;
	logic [MW-1:0] nmod;
	logic [12:0] crc_start;
	logic [12:0] k_off;
	logic        advance;

	// the stage moves when its result can land in the result register this edge or it has none
	assign advance = valid_s1 && ((func_s1 == FUNC_NONE) || !valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_comb begin
		st_n      = st_q;
		has_result = 1'b1;
		r_kind    = KIND_HEADER;
		r_status  = ST_OK;
		r_deliver = 1'b0;
		r_dout    = 8'd0;
		r_offset  = st_q.exp;
		r_lastp   = 1'b0;
		r_ek      = EV_NONE;
		r_ev      = 16'd0;
		hdr_ok    = 1'b1;
		crc_miss  = 1'b0;
		end_r     = 1'b0;
		nmod      = '0;
		crc_start = st_q.pl - 13'd4;
		k_off     = 13'd0;
		case (func_s1)
			FUNC_HEADER: begin
				st_n.pa = 1'b0;
				st_n.fp = 1'b0;
				st_n.bi = 13'd0;
				st_n.pl = 13'd0;
				st_n.rc = 32'd0;
				if (short_s1) begin
					r_status = ST_SHORT;
				end else if (st_n.ap) begin
					r_status = ST_BUSY_ACK;
				end else begin
					// packet zero restarts the transfer from scratch
					if (pnum_s1 == 16'd0) begin
						st_n       = '0;
						st_n.tv    = 1'b1;
						st_n.topic = topic_s1;
						st_n.total = ptot_s1;
					end else if (!st_n.tv) begin
						if (topic_s1 == st_n.topic && pnum_s1 == st_n.exp) begin
							st_n.tv = 1'b1;
						end else begin
							hdr_ok   = 1'b0;
							r_status = ST_UNEXPECT;
						end
					end
					if (hdr_ok) begin
						if (topic_s1 != st_n.topic) begin
							st_n     = f_fail(st_n, fail_limit_q);
							st_n     = f_send_ack(st_n, 16'd0, '0);
							st_n     = f_drop(st_n, 16'd0, '0);
							r_status = ST_TOPIC;
						end else if (pnum_s1 >= ptot_s1) begin
							st_n     = f_fail(st_n, fail_limit_q);
							r_status = ST_BOUNDS;
						end else if (pnum_s1 > st_n.exp) begin
							// ack what we have, uses expected value after a possible give-up
							st_n     = f_fail(st_n, fail_limit_q);
							st_n     = f_send_ack(st_n, st_n.exp, st_n.emod);
							st_n     = f_drop(st_n, st_n.exp, st_n.emod);
							r_status = ST_SKIP;
						end else if (pnum_s1 < st_n.exp) begin
							r_status = ST_DUPLICATE;
						end else begin
							nmod = (st_n.exp == 16'hFFFF || st_n.emod == MOD_TOP) ?
								'0 : MW'(st_n.emod + 1'b1);
							st_n.exp  = st_n.exp + 16'd1;
							st_n.emod = nmod;
							if (nmod == '0) begin
								st_n.pp = 1'b1;
							end
							if (st_n.exp == st_n.total) begin
								if (dlen_s1 < 13'd4) begin
									st_n     = f_fail(st_n, fail_limit_q);
									st_n     = f_send_ack(st_n, 16'd0, '0);
									r_status = ST_CRC_MISS;
									crc_miss = 1'b1;
								end else begin
									st_n.fp = 1'b1;
								end
							end
							if (!crc_miss) begin
								st_n.pa = 1'b1;
								if ({4'd0, dlen_s1} > 17'(MAX_PACKET_BYTES)) begin
									st_n.pl = 13'(MAX_PACKET_BYTES);
								end else begin
									st_n.pl = dlen_s1;
								end
							end
						end
					end
				end
				r_lastp  = st_n.fp;
				r_offset = st_n.exp;
			end
			FUNC_DATA: begin
				r_kind = KIND_DATA;
				if (st_q.pa && st_q.bi < st_q.pl) begin
					r_lastp = st_q.fp;
					if (!st_q.fp || st_q.bi < crc_start) begin
						st_n.crc  = crc32_byte(st_q.crc, byte_s1);
						r_deliver = 1'b1;
						r_dout    = byte_s1;
					end else begin
						// trailing CRC bytes, least significant first
						k_off   = st_q.bi - crc_start;
						st_n.rc = st_q.rc | ({24'd0, byte_s1} << {k_off[1:0], 3'b000});
						end_r   = (st_q.bi == st_q.pl - 13'd1);
					end
					st_n.bi = st_q.bi + 13'd1;
					if (st_n.bi >= st_q.pl) begin
						st_n.pa = 1'b0;
					end
					if (end_r) begin
						r_kind = KIND_END;
						if (st_n.rc != st_n.crc) begin
							st_n     = f_fail(st_n, fail_limit_q);
							st_n     = f_send_ack(st_n, 16'd0, '0);
							r_status = ST_CRC_BAD;
						end else begin
							st_n     = f_send_ack(st_n, st_n.exp, st_n.emod);
							st_n.fc  = 4'd0;
							st_n     = f_drop(st_n, 16'd0, '0);
							r_status = ST_COMPLETE;
						end
						st_n.fp = 1'b0;
					end
				end
			end
			FUNC_POLL: begin
				r_kind = KIND_POLL;
				if (st_q.ap) begin
					r_ek = EV_ACK;
					r_ev = st_q.ackv;
					if (ready_s1) begin
						st_n.ap = 1'b0;
					end
				end else if (st_q.pp) begin
					r_ek = EV_PROGRESS;
					r_ev = st_q.exp;
					if (ready_s1) begin
						st_n.pp = 1'b0;
					end
				end
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_limit_q <= FAIL_LIMIT_RESET;
			st_q         <= '0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
		end else begin
			if (cfg_we) begin
				fail_limit_q <= cfg_wdata;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				st_q <= st_n;
			end
			if (advance && has_result) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			func_s1  <= func_t'(s_axis_tuser);
			topic_s1 <= s_axis_tdata[7:0];
			pnum_s1  <= s_axis_tdata[23:8];
			ptot_s1  <= s_axis_tdata[39:24];
			dlen_s1  <= s_axis_tdata[52:40];
			short_s1 <= s_axis_tdata[53];
			byte_s1  <= s_axis_tdata[61:54];
			ready_s1 <= s_axis_tdata[62];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			kind_s2    <= r_kind;
			status_s2  <= r_status;
			deliver_s2 <= r_deliver;
			dout_s2    <= r_dout;
			offset_s2  <= r_offset;
			lastp_s2   <= r_lastp;
			ek_s2      <= r_ek;
			ev_s2      <= r_ev;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, ev_s2, ek_s2, lastp_s2, offset_s2, dout_s2, status_s2};
	assign m_axis_tuser  = {deliver_s2, kind_s2};

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import seqrx_pkg::*;

	// one input word, unpacked
	typedef struct {
		func_t       func;
		logic [7:0]  topic;
		logic [15:0] pkt_no;
		logic [15:0] pkt_total;
		logic [12:0] length;
		logic        short_hdr;
		logic [7:0]  byte_val;
		logic        link_ready;
	} rx_word_t;

	// one result word, unpacked
	typedef struct {
		kind_t       kind;
		status_t     status;
		logic        deliver;
		logic [7:0]  data_out;
		logic [15:0] offset;
		logic        last_pkt;
		event_t      ev_kind;
		logic [15:0] ev_value;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [3:0]  cfg_wdata = 4'd0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = 64'd0;
	logic [1:0]  s_axis_tuser = FUNC_NONE;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	rx_word_t    word_q[$];     // words waiting to be driven
	result_t     expect_q[$];   // predicted result words, oldest first
	int unsigned words_in = 0;
	int unsigned stim_count = 0;
	int unsigned mismatches = 0;
	bit          word_taken = 1'b0;
	bit          quiet = 1'b0;  // no idling on either side
	logic        rx_hold = 1'b0;

	// receiver shadow state
	logic        rx_open = 1'b0;
	logic [7:0]  rx_topic = 8'd0;
	logic [15:0] next_pkt = 16'd0;
	logic [15:0] pkt_count = 16'd0;
	logic [31:0] crc_acc = 32'd0;
	logic [3:0]  fail_cnt = 4'd0;
	logic        ack_owed = 1'b0;
	logic        progress_owed = 1'b0;
	logic [15:0] ack_word = 16'd0;
	logic        in_packet = 1'b0;
	logic        on_last = 1'b0;
	logic [12:0] byte_pos = 13'd0;
	logic [12:0] pkt_len = 13'd0;
	logic [31:0] crc_seen = 32'd0;
	logic [3:0]  limit_reg = FAIL_LIMIT_RESET;

	sequenced_transfer_receiver_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	// reflected CRC-32 over one byte, ones-complemented on both sides
	function automatic logic [31:0] crc_next(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] r;
		r = ~acc ^ {24'd0, b};
		repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
		return ~r;
	endfunction

	function automatic void wipe();
		rx_open = 1'b0;
		rx_topic = 8'd0;
		next_pkt = 16'd0;
		pkt_count = 16'd0;
		crc_acc = 32'd0;
		fail_cnt = 4'd0;
		ack_owed = 1'b0;
		progress_owed = 1'b0;
		ack_word = 16'd0;
		in_packet = 1'b0;
		on_last = 1'b0;
		byte_pos = 13'd0;
		pkt_len = 13'd0;
		crc_seen = 32'd0;
	endfunction

	// ack also rewinds the expected packet and cancels a pending progress report
	function automatic void post_ack(input logic [15:0] v);
		ack_word = v;
		next_pkt = v;
		ack_owed = 1'b1;
		progress_owed = 1'b0;
	endfunction

	function automatic void abandon(input logic [15:0] to);
		rx_open = 1'b0;
		next_pkt = to;
		if (to == 16'd0) begin
			pkt_count = 16'd0;
			crc_acc = 32'd0;
		end
	endfunction

	// saturating fail counter; at the limit give up with an all-ones ack
	function automatic void count_failure();
		if (fail_cnt != 4'd15)
			fail_cnt++;
		if (fail_cnt >= limit_reg) begin
			abandon(16'd0);
			post_ack(GIVE_UP_ACK);
		end
	endfunction

	function automatic status_t judge_header(input rx_word_t w);
		if (w.short_hdr)
			return ST_SHORT;
		if (ack_owed)
			return ST_BUSY_ACK;
		if (w.pkt_no == 16'd0) begin
			wipe();
			rx_open = 1'b1;
			rx_topic = w.topic;
			pkt_count = w.pkt_total;
		end else if (!rx_open) begin
			// a closed transfer resumes only at the packet it last asked for
			if (w.topic == rx_topic && w.pkt_no == next_pkt)
				rx_open = 1'b1;
			else
				return ST_UNEXPECT;
		end
		if (w.topic != rx_topic) begin
			count_failure();
			post_ack(16'd0);
			abandon(16'd0);
			return ST_TOPIC;
		end
		if (w.pkt_no >= w.pkt_total) begin
			count_failure();
			return ST_BOUNDS;
		end
		if (w.pkt_no > next_pkt) begin
			count_failure();
			post_ack(next_pkt);
			abandon(next_pkt);
			return ST_SKIP;
		end
		if (w.pkt_no < next_pkt)
			return ST_DUPLICATE;
		next_pkt = next_pkt + 16'd1;
		if (next_pkt % PROGRESS_EVERY_DEF == 0)
			progress_owed = 1'b1;
		if (next_pkt == pkt_count) begin
			if (w.length < 13'd4) begin
				count_failure();
				post_ack(16'd0);
				return ST_CRC_MISS;
			end
			on_last = 1'b1;
		end
		in_packet = 1'b1;
		pkt_len = (w.length > MAX_PACKET_BYTES) ? 13'(MAX_PACKET_BYTES) : w.length;
		return ST_OK;
	endfunction

	// returns 0 for words that give no result
	function automatic bit predict_result(input rx_word_t w, output result_t r);
		logic [12:0] slot;
		bit closes;
		closes = 1'b0;
		r.kind = KIND_HEADER;
		r.status = ST_OK;
		r.deliver = 1'b0;
		r.data_out = 8'd0;
		r.offset = 16'd0;
		r.last_pkt = 1'b0;
		r.ev_kind = EV_NONE;
		r.ev_value = 16'd0;
		case (w.func)
			FUNC_NONE: return 1'b0;
			FUNC_HEADER: begin
				in_packet = 1'b0;
				on_last = 1'b0;
				byte_pos = 13'd0;
				pkt_len = 13'd0;
				crc_seen = 32'd0;
				r.status = judge_header(w);
				r.last_pkt = on_last;
				r.offset = next_pkt;
			end
			FUNC_DATA: begin
				r.kind = KIND_DATA;
				r.offset = next_pkt;
				if (in_packet && byte_pos < pkt_len) begin
					r.last_pkt = on_last;
					if (!on_last || byte_pos < pkt_len - 13'd4) begin
						crc_acc = crc_next(crc_acc, w.byte_val);
						r.deliver = 1'b1;
						r.data_out = w.byte_val;
					end else begin
						// trailing CRC, least significant byte first
						slot = byte_pos - (pkt_len - 13'd4);
						crc_seen = crc_seen | ({24'd0, w.byte_val} << (8 * slot[1:0]));
						closes = (byte_pos == pkt_len - 13'd1);
					end
					byte_pos++;
					if (byte_pos >= pkt_len)
						in_packet = 1'b0;
					if (closes) begin
						r.kind = KIND_END;
						if (crc_seen != crc_acc) begin
							count_failure();
							post_ack(16'd0);
							r.status = ST_CRC_BAD;
						end else begin
							post_ack(next_pkt);
							fail_cnt = 4'd0;
							abandon(16'd0);
							r.status = ST_COMPLETE;
						end
						on_last = 1'b0;
					end
				end
			end
			default: begin
				r.kind = KIND_POLL;
				if (ack_owed) begin
					r.ev_kind = EV_ACK;
					r.ev_value = ack_word;
					if (w.link_ready)
						ack_owed = 1'b0;
				end else if (progress_owed) begin
					r.ev_kind = EV_PROGRESS;
					r.ev_value = next_pkt;
					if (w.link_ready)
						progress_owed = 1'b0;
				end
				r.offset = next_pkt;
			end
		endcase
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------- stimulus builders

	task automatic queue_word(input func_t f, input logic [7:0] t, input logic [15:0] pn,
			input logic [15:0] tp, input logic [12:0] dl, input logic sh,
			input logic [7:0] b, input logic rdy);
		rx_word_t w;
		w.func = f;
		w.topic = t;
		w.pkt_no = pn;
		w.pkt_total = tp;
		w.length = dl;
		w.short_hdr = sh;
		w.byte_val = b;
		w.link_ready = rdy;
		word_q.push_back(w);
		if (f != FUNC_NONE)
			stim_count++;
	endtask

	// unused fields carry random values
	task automatic queue_header(input logic [7:0] t, input logic [15:0] pn,
			input logic [15:0] tp, input logic [12:0] dl, input logic sh);
		queue_word(FUNC_HEADER, t, pn, tp, dl, sh, 8'($urandom), 1'($urandom));
	endtask

	task automatic queue_byte(input logic [7:0] b);
		queue_word(FUNC_DATA, 8'($urandom), 16'($urandom), 16'($urandom),
			13'($urandom_range(0, 4096)), 1'($urandom), b, 1'($urandom));
	endtask

	task automatic queue_poll(input logic rdy);
		queue_word(FUNC_POLL, 8'($urandom), 16'($urandom), 16'($urandom),
			13'($urandom_range(0, 4096)), 1'($urandom), 8'($urandom), rdy);
	endtask

	task automatic queue_noise();
		queue_word(func_t'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
			16'($urandom), 13'($urandom_range(0, 4096)), $urandom_range(0, 3) == 0,
			8'($urandom), 1'($urandom));
	endtask

	// one numbered transfer, mostly clean, with the odd fault mixed in
	task automatic queue_transfer();
		logic [7:0]  topic;
		logic [15:0] total;
		logic [31:0] acc;
		logic [7:0]  b;
		int unsigned len;
		bit          closing;
		topic = 8'($urandom_range(0, 255));
		total = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(5, 12))
			: 16'($urandom_range(1, 4));
		acc = 32'd0;
		for (int p = 0; p < int'(total); p++) begin
			closing = (p == int'(total) - 1);
			// a pending ack blocks headers; usually take it first
			if ((p == 0 && $urandom_range(0, 7) != 0) || $urandom_range(0, 2) == 0)
				queue_poll(1'b1);
			case ($urandom_range(0, 19))
				0: begin
					queue_header(topic, 16'(p + 1 + $urandom_range(0, 2)), total + 16'd4,
						13'd0, 1'b0);
					queue_poll(1'b1);
				end
				1: begin
					queue_header(topic ^ 8'($urandom_range(1, 255)), 16'(p), total, 13'd4, 1'b0);
					queue_poll(1'b1);
				end
				2: queue_header(topic, total + 16'($urandom_range(0, 3)), total, 13'd0, 1'b0);
				3: queue_header(topic, 16'(p), total, 13'd4, 1'b1);
				4: queue_word(FUNC_NONE, topic, 16'(p), total, 13'd0, 1'b0, 8'($urandom), 1'b1);
				5: queue_byte(8'($urandom));
				6: if (p > 0) queue_header(topic, 16'(p - 1), total, 13'd2, 1'b0);
				default: ;
			endcase
			len = closing ? $urandom_range(4, 12) : $urandom_range(0, 8);
			if (closing && $urandom_range(0, 15) == 0)
				len = $urandom_range(0, 3);
			queue_header(topic, 16'(p), total, 13'(len), 1'b0);
			if (!closing || len >= 4) begin
				for (int k = 0; k < int'(closing ? len - 4 : len); k++) begin
					b = 8'($urandom);
					acc = crc_next(acc, b);
					queue_byte(b);
				end
			end
			if (closing && len >= 4) begin
				if ($urandom_range(0, 9) == 0)
					acc = acc ^ (32'd1 << $urandom_range(0, 31));
				for (int k = 0; k < 4; k++)
					queue_byte(acc[8 * k +: 8]);
			end
			if ($urandom_range(0, 15) == 0)
				queue_byte(8'($urandom));
		end
	endtask

	// run of bounds failures to reach the give-up limit
	task automatic queue_storm();
		logic [7:0] topic;
		topic = 8'($urandom_range(0, 255));
		queue_poll(1'b1);
		queue_header(topic, 16'd0, 16'd2, 13'd0, 1'b0);
		repeat ($urandom_range(1, 16))
			queue_header(topic, 16'($urandom_range(2, 16'hFFFF)), 16'd2,
				13'($urandom_range(0, 4096)), 1'b0);
		queue_poll(1'b1);
	endtask

	// big packet opened, only a few bytes sent before the next header cuts it off
	task automatic queue_long();
		queue_poll(1'b1);
		queue_header(8'($urandom), 16'd0, 16'($urandom_range(1, 16'hFFFF)),
			($urandom_range(0, 1) == 1) ? 13'd4096 : 13'($urandom_range(1000, 4096)), 1'b0);
		repeat ($urandom_range(1, 6))
			queue_byte(8'($urandom));
	endtask

	task automatic run_phase(input int unsigned n);
		stim_count = 0;
		while (stim_count < n) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: queue_transfer();
				6: repeat ($urandom_range(1, 6)) queue_noise();
				7: queue_storm();
				8: queue_long();
				default: repeat ($urandom_range(1, 4)) queue_poll(1'($urandom_range(0, 1)));
			endcase
		end
	endtask

	// idle: nothing queued, nothing in flight, plus pipeline slack for selector-3 words
	task automatic settle();
		while (word_q.size() != 0 || s_axis_tvalid || expect_q.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic set_fail_limit(input logic [3:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		limit_reg = v;
	endtask

	// ---------------------------------------------------------------- driver

	always @(negedge clk) begin : drive_words
		rx_word_t w;
		int unsigned gap_left;
		if (!s_axis_tvalid || word_taken) begin
			if (gap_left == 0 && !quiet && word_q.size() != 0 && $urandom_range(0, 9) == 0)
				gap_left = $urandom_range(1, 5);
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (word_q.size() != 0) begin
				w = word_q.pop_front();
				s_axis_tdata <= {1'b0, w.link_ready, w.byte_val, w.short_hdr, w.length,
					w.pkt_total, w.pkt_no, w.topic};
				s_axis_tuser <= w.func;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result-side backpressure; a long hold overrides the random stalls
	always @(negedge clk) begin : pace_results
		int unsigned stall_left;
		if (rx_hold) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 5);
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : long_hold
		while (words_in < 200)
			@(negedge clk);
		rx_hold <= 1'b1;
		repeat (300) @(negedge clk);
		rx_hold <= 1'b0;
	end

	// ---------------------------------------------------------------- accept and check

	always @(posedge clk) begin : take_words
		rx_word_t w;
		result_t  r;
		word_taken = arst_n && s_axis_tvalid && s_axis_tready;
		if (word_taken) begin
			w.topic = s_axis_tdata[7:0];
			w.pkt_no = s_axis_tdata[23:8];
			w.pkt_total = s_axis_tdata[39:24];
			w.length = s_axis_tdata[52:40];
			w.short_hdr = s_axis_tdata[53];
			w.byte_val = s_axis_tdata[61:54];
			w.link_ready = s_axis_tdata[62];
			w.func = func_t'(s_axis_tuser);
			words_in++;
			if (predict_result(w, r))
				expect_q.push_back(r);
		end
	end

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expect_q.size() == 0) begin
				$error("result word with nothing expected: tdata %h tuser %h",
					m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				want = expect_q.pop_front();
				check_field("result_kind", want.kind, m_axis_tuser[1:0]);
				check_field("deliver", want.deliver, m_axis_tuser[2]);
				check_field("status", want.status, m_axis_tdata[3:0]);
				check_field("data_out", want.data_out, m_axis_tdata[11:4]);
				check_field("packet_offset", want.offset, m_axis_tdata[27:12]);
				check_field("last_pkt", want.last_pkt, m_axis_tdata[28]);
				check_field("event_kind", want.ev_kind, m_axis_tdata[30:29]);
				check_field("event_value", want.ev_value, m_axis_tdata[46:31]);
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin : stimulus
		logic [31:0] acc;
		logic [3:0]  lim;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: idle poll, short header, stray byte, unexpected, selector 3
		queue_poll(1'b0);
		queue_header(8'hFF, 16'hFFFF, 16'hFFFF, 13'd4096, 1'b1);
		queue_byte(8'hA5);
		queue_header(8'h00, 16'd5, 16'd9, 13'd3, 1'b0);
		queue_word(FUNC_NONE, 8'hFF, 16'hFFFF, 16'hFFFF, 13'd4096, 1'b1, 8'hFF, 1'b1);
		// single-packet transfer, then a header while its ack is still owed
		acc = crc_next(32'd0, 8'hFF);
		queue_header(8'hFF, 16'd0, 16'd1, 13'd5, 1'b0);
		queue_byte(8'hFF);
		for (int k = 0; k < 4; k++)
			queue_byte(acc[8 * k +: 8]);
		queue_header(8'hFF, 16'd0, 16'd1, 13'd5, 1'b0);
		queue_poll(1'b0);
		queue_poll(1'b1);
		// largest packet opened, then restart, duplicate, bounds, skip
		queue_header(8'h5A, 16'd0, 16'hFFFF, 13'd4096, 1'b0);
		queue_byte(8'h00);
		queue_header(8'h5A, 16'd0, 16'd3, 13'd1, 1'b0);
		queue_byte(8'h3C);
		queue_header(8'h5A, 16'd1, 16'd3, 13'd0, 1'b0);
		queue_header(8'h5A, 16'd1, 16'd3, 13'd0, 1'b0);
		queue_header(8'h5A, 16'd7, 16'd3, 13'd0, 1'b0);
		queue_header(8'h5A, 16'd3, 16'd5, 13'd0, 1'b0);
		queue_poll(1'b1);
		// resume at the asked packet, which is last but too short for a CRC
		queue_header(8'h5A, 16'd2, 16'd3, 13'd2, 1'b0);
		queue_poll(1'b1);
		// other topic mid-transfer
		queue_header(8'h33, 16'd0, 16'd2, 13'd4, 1'b0);
		queue_header(8'h44, 16'd1, 16'd2, 13'd4, 1'b0);
		queue_poll(1'b1);
		settle();

		// random phases over several fail limits, extremes first; last one without idling
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: lim = 4'd1;
				1: lim = 4'd15;
				5: lim = FAIL_LIMIT_RESET;
				default: lim = 4'($urandom_range(2, 14));
			endcase
			if (ph == 5)
				quiet = 1'b1;
			set_fail_limit(lim);
			run_phase(100);
			settle();
		end

		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog
		#(2_000_000);
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/seqrx_pkg.sv
sv/sequenced_transfer_receiver_unit.sv
bench/tb_top.sv
